>>> hw/rtl/hex_text_to_bytes_top_assert.svh
// assertion macros for the hex text decoder
// used by hex_text_to_bytes_top; no other dependencies
`ifndef HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH
`define HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex_text_to_bytes assertion failed");

// next-cycle implication, checked outside reset
`define HTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex_text_to_bytes assertion failed");

`endif

>>> hw/rtl/hexbyt_pkg.sv
// constants, types and the digit decoder for the hex text decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hexbyt_pkg;

  localparam int MAX_TEXT_CHARS = 255;
  localparam int BYTE_LIMIT     = MAX_TEXT_CHARS / 2;
  localparam int COUNT_W        = 7;
  localparam int COMMA_LIMIT    = 2;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;

  localparam logic [COUNT_W-1:0] BYTE_MAX = COUNT_W'(BYTE_LIMIT);
  localparam logic [1:0]         RUN_MAX  = 2'd3;
  localparam logic [1:0]         RUN_LIM  = 2'(COMMA_LIMIT);

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } nib_dec_t;

  // upper-case hex digit to nibble
  function automatic nib_dec_t dec_digit(input logic [7:0] ch);
    nib_dec_t d;
    logic [7:0] diff;
    d.ok  = 1'b0;
    d.nib = 4'd0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      diff  = ch - CHAR_ZERO;
      d.ok  = 1'b1;
      d.nib = diff[3:0];
    end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
      diff  = ch - CHAR_UP_A + 8'd10;
      d.ok  = 1'b1;
      d.nib = diff[3:0];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hex_text_to_bytes_top.sv
// Hex text decoder: takes one ASCII character per word, pairs upper-case hex
// digits into bytes (high nibble first) and emits each byte as it completes;
// a single comma may follow only a whole byte. An end word (in_tlast) returns a
// status word with success and byte count and clears the state for the next
// text. Any error is sticky until the end word. The decode is one short step
// between the state registers and the output register, so a character is
// accepted on every cycle the output register is empty or being drained, and
// its result is registered in the output register in the cycle after it is accepted.
// Depends on hexbyt_pkg and hex_text_to_bytes_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "hex_text_to_bytes_top_assert.svh"

module hex_text_to_bytes_top
  import hexbyt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_char
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data_byte, [8] success, [15:9] byte_total
  output logic             out_tuser   // is_status
);

  // decoder state
  logic               odd_r, odd_nxt;
  logic [3:0]         held_r, held_nxt;
  logic [1:0]         run_r, run_nxt;
  logic               seen_r, seen_nxt;
  logic               err_r, err_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_stat_r, out_stat_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic       in_acc;
  logic       end_acc;
  logic       load;
  logic [1:0] run_inc;
  nib_dec_t   dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign end_acc   = in_acc && in_tlast;
  assign run_inc   = (run_r < RUN_MAX) ? run_r + 2'd1 : run_r;
  assign dec       = dec_digit(in_tdata);

  // next state and result
  always_comb begin
    odd_nxt      = odd_r;
    held_nxt     = held_r;
    run_nxt      = run_r;
    seen_nxt     = seen_r;
    err_nxt      = err_r;
    done_nxt     = done_r;
    load         = 1'b0;
    out_stat_nxt = 1'b0;
    out_data_nxt = 8'd0;
    out_ok_nxt   = 1'b0;
    out_cnt_nxt  = done_r;
    if (in_acc) begin
      if (in_tlast) begin
        load         = 1'b1;
        out_stat_nxt = 1'b1;
        out_ok_nxt   = !err_r && !odd_r;
        odd_nxt      = 1'b0;
        held_nxt     = 4'd0;
        run_nxt      = 2'd0;
        seen_nxt     = 1'b0;
        err_nxt      = 1'b0;
        done_nxt     = '0;
      end else if (!err_r) begin
        if (in_tdata == CHAR_COMMA) begin
          run_nxt = run_inc;
          if (!seen_r || odd_r || run_inc >= RUN_LIM) begin
            err_nxt = 1'b1;
          end else begin
            seen_nxt = 1'b1;
          end
        end else begin
          run_nxt = 2'd0;
          if (!dec.ok) begin
            err_nxt = 1'b1;
          end else begin
            seen_nxt = 1'b1;
            if (odd_r) begin
              odd_nxt      = 1'b0;
              done_nxt     = (done_r < BYTE_MAX) ? done_r + 1'b1 : done_r;
              load         = 1'b1;
              out_data_nxt = {held_r, dec.nib};
              out_cnt_nxt  = done_nxt;
            end else begin
              held_nxt = dec.nib;
              odd_nxt  = 1'b1;
            end
          end
        end
      end
    end
    out_valid_nxt = load || (out_valid_r && !out_tready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r       <= 1'b0;
      held_r      <= 4'd0;
      run_r       <= 2'd0;
      seen_r      <= 1'b0;
      err_r       <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      odd_r       <= odd_nxt;
      held_r      <= held_nxt;
      run_r       <= run_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_stat_r <= out_stat_nxt;
      out_data_r <= out_data_nxt;
      out_ok_r   <= out_ok_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {out_cnt_r, out_ok_r, out_data_r};

  // checks
  `HTB_ASSERT_NOW(a_byte_counted, clk, rst_n, out_valid_r && !out_stat_r, out_cnt_r != '0 && !out_ok_r)
  `HTB_ASSERT_NEXT(a_end_clears, clk, rst_n, end_acc, done_r == '0 && !err_r && !odd_r && !seen_r)
  `HTB_ASSERT_NEXT(a_end_reports, clk, rst_n, end_acc, out_valid_r && out_stat_r)
  `HTB_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r && !end_acc, err_r)

endmodule

`default_nettype wire

>>> test/hex_text_to_bytes_top_test.sv
// testbench for hex_text_to_bytes_top: directed and random hex texts, checked word by word
// against a behavioral decoder kept in a small scoreboard class
// depends on hexbyt_pkg and the hex_text_to_bytes_top rtl
`timescale 1ns / 1ps

import hexbyt_pkg::*;

// one expected output word
typedef struct packed {
  logic               is_status;
  logic [7:0]         data_byte;
  logic               success;
  logic [COUNT_W-1:0] byte_total;
} dec_word_t;

// tracks the decode state of the current text and the words still owed by the block
class hex_byte_tracker;
  logic               half_pending;
  logic [3:0]         upper_nib;
  logic [1:0]         commas_in_row;
  logic               text_started;
  logic               text_broken;
  logic [COUNT_W-1:0] byte_tally;
  dec_word_t          expected_words[$];
  int                 mismatches;

  function new();
    clear_text();
    mismatches = 0;
  endfunction

  function void clear_text();
    half_pending  = 1'b0;
    upper_nib     = 4'd0;
    commas_in_row = 2'd0;
    text_started  = 1'b0;
    text_broken   = 1'b0;
    byte_tally    = '0;
  endfunction

  // note one accepted input word and queue the word it should produce
  function void note_char(input logic [7:0] ch, input logic last);
    dec_word_t w;
    logic [3:0] nib;
    // end word: report status and start a fresh text
    if (last) begin
      w.is_status  = 1'b1;
      w.data_byte  = 8'd0;
      w.success    = !text_broken && !half_pending;
      w.byte_total = byte_tally;
      expected_words.push_back(w);
      clear_text();
      return;
    end
    // sticky error swallows everything up to the end word
    if (text_broken)
      return;
    // separator: legal only after a whole byte and never twice in a row
    if (ch == CHAR_COMMA) begin
      if (commas_in_row != RUN_MAX)
        commas_in_row = commas_in_row + 2'd1;
      if (!text_started || half_pending || commas_in_row >= RUN_LIM)
        text_broken = 1'b1;
      return;
    end
    commas_in_row = 2'd0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      nib = 4'(ch - CHAR_ZERO);
    end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
      nib = 4'(ch - CHAR_UP_A + 8'd10);
    end else begin
      text_broken = 1'b1;
      return;
    end
    text_started = 1'b1;
    // second digit completes a byte
    if (half_pending) begin
      half_pending = 1'b0;
      if (byte_tally < BYTE_MAX)
        byte_tally = byte_tally + 1'b1;
      w.is_status  = 1'b0;
      w.data_byte  = {upper_nib, nib};
      w.success    = 1'b0;
      w.byte_total = byte_tally;
      expected_words.push_back(w);
    end else begin
      upper_nib    = nib;
      half_pending = 1'b1;
    end
  endfunction

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // compare one accepted output word with the oldest expectation
  task check_word(input logic tuser, input logic [15:0] tdata);
    dec_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word tuser=%0b tdata=%h", tuser, tdata));
      return;
    end
    want = expected_words.pop_front();
    if (tuser !== want.is_status)
      report_mismatch($sformatf("is_status %0b, want %0b", tuser, want.is_status));
    if (tdata[7:0] !== want.data_byte)
      report_mismatch($sformatf("data_byte %h, want %h", tdata[7:0], want.data_byte));
    if (tdata[8] !== want.success)
      report_mismatch($sformatf("success %0b, want %0b", tdata[8], want.success));
    if (tdata[15:9] !== want.byte_total)
      report_mismatch($sformatf("byte_total %0d, want %0d", tdata[15:9], want.byte_total));
  endtask

  function int pending();
    return expected_words.size();
  endfunction
endclass

module hex_text_to_bytes_top_test;

  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam int         RANDOM_WORDS = 1150;
  localparam int         LONG_BYTES   = 135;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  hex_byte_tracker tracker = new();

  logic [7:0] text_buf[$];
  int         words_sent = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         mode_left  = 0;
  int         stall_period = 2;
  int         stall_tick = 0;

  hex_text_to_bytes_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        tracker.check_word(out_tuser, out_tdata);
    end
  end

  // receiver: always ready, coin-flip stalls, or ready once per period
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode   = $urandom_range(0, 2);
      mode_left    = $urandom_range(30, 200);
      stall_period = $urandom_range(2, 5);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_tready <= (stall_tick % stall_period) == 0;
      end
    endcase
  end

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10)
      return CHAR_ZERO + 8'(v);
    return CHAR_UP_A + 8'(v - 10);
  endfunction

  // any character that is neither an upper-case hex digit nor a comma
  function automatic logic [7:0] invalid_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UP_A && c <= CHAR_UP_F) ||
               c == CHAR_COMMA);
    return c;
  endfunction

  // one word in bursts with random gaps, held until accepted
  task automatic send_word(input logic [7:0] ch, input logic last);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    burst_left--;
    words_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // send the buffered characters, then an end word with a random ignored character
  task automatic send_text();
    foreach (text_buf[i])
      send_word(text_buf[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    text_buf.delete();
  endtask

  task automatic send_literal(input string s);
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
    send_text();
  endtask

  // add one fault to an otherwise clean text (a lone comma is an error only at the start or beside another comma)
  task automatic add_fault();
    case ($urandom_range(0, 4))
      0: begin
        text_buf.push_back(invalid_char());
      end
      1: begin
        text_buf.push_back(CHAR_COMMA);
        text_buf.push_back(CHAR_COMMA);
      end
      2: begin
        text_buf.push_back(hex_char($urandom_range(0, 15)));
        text_buf.push_back(CHAR_COMMA);
      end
      3: begin
        text_buf.push_back(hex_char($urandom_range(0, 15)));
      end
      default: begin
        text_buf.push_back(CHAR_COMMA);
      end
    endcase
  endtask

  // mostly well-formed texts, some with one fault, some pure noise
  task automatic build_random_text();
    int kind;
    int nbytes;
    int fault_at;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      nbytes   = $urandom_range(0, 12);
      fault_at = (kind >= 70) ? $urandom_range(0, nbytes) : -1;
      for (int i = 0; i < nbytes; i++) begin
        if (i == fault_at)
          add_fault();
        if (i > 0 && $urandom_range(0, 2) == 0)
          text_buf.push_back(CHAR_COMMA);
        text_buf.push_back(hex_char($urandom_range(0, 15)));
        text_buf.push_back(hex_char($urandom_range(0, 15)));
      end
      if (fault_at == nbytes)
        add_fault();
      if ($urandom_range(0, 7) == 0)
        text_buf.push_back(CHAR_COMMA);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 3) == 0)
          text_buf.push_back(hex_char($urandom_range(0, 15)));
        else
          text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // overall run limit
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit long_done;
    long_done = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed texts: empty, digit extremes, each error kind, dangling nibble
    send_literal("");
    send_literal("09,AF");
    send_literal(",1");
    send_literal("1,2");
    send_literal("7E,,3");
    send_literal("5");
    text_buf.push_back(CHAR_LOW_A);
    send_text();

    // random texts, with one over-long text that drives the count into saturation
    while (words_sent < RANDOM_WORDS) begin
      if (!long_done && words_sent > RANDOM_WORDS / 2) begin
        long_done = 1'b1;
        for (int i = 0; i < LONG_BYTES; i++) begin
          if (i > 0 && $urandom_range(0, 3) == 0)
            text_buf.push_back(CHAR_COMMA);
          text_buf.push_back(hex_char($urandom_range(0, 15)));
          text_buf.push_back(hex_char($urandom_range(0, 15)));
        end
      end else begin
        build_random_text();
      end
      send_text();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain the outstanding words, then keep watching for stray words before the verdict
    while (tracker.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hexbyt_pkg.sv
hw/rtl/hex_text_to_bytes_top.sv
test/hex_text_to_bytes_top_test.sv
